@@ rtl/erff_pkg.sv @@
// ----------------------------------------------------------------------------
// Ethernet receive frame filter package
// Beat and verdict types, status and protocol codes, CRC-32 byte step.
// ----------------------------------------------------------------------------
package erff_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 2048;
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LEN_W = 12;

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  localparam logic [1:0] REG_OWN_MAC   = 2'd0;
  localparam logic [1:0] REG_ADDR_CHK  = 2'd1;
  localparam logic [1:0] REG_FCS_CHK   = 2'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_RUNT     = 3'd1;
  localparam logic [2:0] STATUS_ADDR     = 3'd2;
  localparam logic [2:0] STATUS_BAD_FCS  = 3'd3;
  localparam logic [2:0] STATUS_ETYPE    = 3'd4;

  localparam logic [2:0] PROTO_IPV4      = 3'd0;
  localparam logic [2:0] PROTO_IPV6      = 3'd1;
  localparam logic [2:0] PROTO_ARP       = 3'd2;
  localparam logic [2:0] PROTO_PPPOE_DISC = 3'd3;
  localparam logic [2:0] PROTO_PPPOE_SESS = 3'd4;

  localparam logic [15:0] ETYPE_IPV4       = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6       = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP        = 16'h0806;
  localparam logic [15:0] ETYPE_PPPOE_DISC = 16'h8863;
  localparam logic [15:0] ETYPE_PPPOE_SESS = 16'h8864;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } rx_beat_t;

  typedef struct packed {
    logic             accepted;
    logic [2:0]       status;
    logic [2:0]       protocol;
    logic [LEN_W-1:0] frame_length;
  } verdict_t;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/ethernet_rx_frame_filter_top.sv @@
// ----------------------------------------------------------------------------
// Ethernet receive frame filter
// Checks runt length, destination address, FCS and ethertype of a received
// frame, one byte per beat, and gives one verdict beat per frame.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                        | payload
//  in      | input     | in_valid_i / in_stall_o          | in_i  (rx_beat_t)
//  out     | output    | out_valid_o / out_stall_i        | out_o (verdict_t)
//  config  | input     | psel/penable/pwrite/pready       | paddr, pwdata, prdata
//
//  One byte beat per cycle while no stalled verdict holds a final byte; the
//  bytewise CRC-32 step sets the path from the input register to the frame
//  state and verdict register. A verdict is registered from the final beat.
//  Reset clears config registers and valid flags to zero, frame state to idle.
//  A stalled verdict holds only final-byte beats; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_filter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  erff_pkg::rx_beat_t              in_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output erff_pkg::verdict_t              out_o,
  input  logic                            out_stall_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [erff_pkg::APB_AW-1:0]     paddr,
  input  logic [erff_pkg::APB_DW-1:0]     pwdata,
  output logic [erff_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import erff_pkg::*;

  logic [47:0] own_mac_q;
  logic        addr_chk_en_q;
  logic        fcs_chk_en_q;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic        in_valid_q;
  rx_beat_t    in_q;
  logic        advance;
  logic        in_accept;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      tail_q, tail_d;
  logic             own_match_q, own_match_d;
  logic             bcast_match_q, bcast_match_d;
  logic [15:0]      etype_q, etype_d;

  logic             out_valid_q;
  verdict_t         out_q, verdict_d;

  logic [7:0]       mac_byte;
  logic [CNT_W-1:0] len;
  logic [31:0]      fcs_rx;
  logic [2:0]       status;
  logic [2:0]       proto;
  logic             etype_known;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_OWN_MAC:  prdata = {16'd0, own_mac_q};
      REG_ADDR_CHK: prdata = {63'd0, addr_chk_en_q};
      REG_FCS_CHK:  prdata = {63'd0, fcs_chk_en_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q     <= '0;
      addr_chk_en_q <= 1'b0;
      fcs_chk_en_q  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OWN_MAC:  own_mac_q     <= pwdata[47:0];
        REG_ADDR_CHK: addr_chk_en_q <= pwdata[0];
        REG_FCS_CHK:  fcs_chk_en_q  <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // input register; only a final byte needs room in the verdict register
  assign advance    = in_valid_q && (!in_q.frame_end || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_i;
    end
  end

  // per-byte frame state update
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    mac_byte = own_mac_q[47:40];
      3'd1:    mac_byte = own_mac_q[39:32];
      3'd2:    mac_byte = own_mac_q[31:24];
      3'd3:    mac_byte = own_mac_q[23:16];
      3'd4:    mac_byte = own_mac_q[15:8];
      3'd5:    mac_byte = own_mac_q[7:0];
      default: mac_byte = 8'd0;
    endcase
  end

  always_comb begin
    own_match_d   = own_match_q;
    bcast_match_d = bcast_match_q;
    etype_d       = etype_q;
    if (cnt_q < CNT_W'(6)) begin
      if (in_q.frame_byte != mac_byte) own_match_d = 1'b0;
      if (in_q.frame_byte != 8'hFF)    bcast_match_d = 1'b0;
    end
    if (cnt_q == CNT_W'(12)) etype_d[15:8] = in_q.frame_byte;
    if (cnt_q == CNT_W'(13)) etype_d[7:0]  = in_q.frame_byte;
    crc_d  = (cnt_q >= CNT_W'(4)) ? crc32_byte(crc_q, tail_q[31:24]) : crc_q;
    tail_d = {tail_q[23:0], in_q.frame_byte};
    cnt_d  = (cnt_q < CNT_W'(MAX_FRAME_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;
  end

  // verdict on the final byte
  assign fcs_rx = {tail_d[7:0], tail_d[15:8], tail_d[23:16], tail_d[31:24]};

  always_comb begin
    etype_known = 1'b1;
    proto       = PROTO_IPV4;
    case (etype_d)
      ETYPE_IPV4:       proto = PROTO_IPV4;
      ETYPE_IPV6:       proto = PROTO_IPV6;
      ETYPE_ARP:        proto = PROTO_ARP;
      ETYPE_PPPOE_DISC: proto = PROTO_PPPOE_DISC;
      ETYPE_PPPOE_SESS: proto = PROTO_PPPOE_SESS;
      default:          etype_known = 1'b0;
    endcase
  end

  always_comb begin
    len    = cnt_d;
    status = STATUS_OK;
    if (cnt_d < CNT_W'(14)) begin
      status = STATUS_RUNT;
    end else if (addr_chk_en_q && !own_match_d && !bcast_match_d) begin
      status = STATUS_ADDR;
    end else begin
      if (fcs_chk_en_q && cnt_d > CNT_W'(18)) begin
        len = cnt_d - CNT_W'(4);
        if (~crc_d != fcs_rx) status = STATUS_BAD_FCS;
      end
      if (status == STATUS_OK && !etype_known) status = STATUS_ETYPE;
    end
    verdict_d.accepted     = (status == STATUS_OK);
    verdict_d.status       = status;
    verdict_d.protocol     = (status == STATUS_OK) ? proto : PROTO_IPV4;
    verdict_d.frame_length = LEN_W'(len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      crc_q         <= CRC_INIT;
      tail_q        <= '0;
      own_match_q   <= 1'b1;
      bcast_match_q <= 1'b1;
      etype_q       <= '0;
    end else if (advance) begin
      if (in_q.frame_end) begin
        cnt_q         <= '0;
        crc_q         <= CRC_INIT;
        tail_q        <= '0;
        own_match_q   <= 1'b1;
        bcast_match_q <= 1'b1;
        etype_q       <= '0;
      end else begin
        cnt_q         <= cnt_d;
        crc_q         <= crc_d;
        tail_q        <= tail_d;
        own_match_q   <= own_match_d;
        bcast_match_q <= bcast_match_d;
        etype_q       <= etype_d;
      end
    end
  end

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.frame_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.frame_end) begin
      out_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.accepted == (out_o.status == STATUS_OK)))
    else $error("accepted flag disagrees with status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.accepted |-> out_o.protocol == PROTO_IPV4)
    else $error("rejected frame carries a protocol");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAME_BYTES))
    else $error("byte count beyond saturation limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.frame_end |=> cnt_q == '0 && crc_q == CRC_INIT && out_valid_q)
    else $error("frame state not cleared after final byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && in_q.frame_end && out_valid_q)
    else $error("input stalled without a pending verdict");

endmodule

@@ dv/ethernet_rx_frame_filter_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ethernet receive frame filter testbench
// Streams frames byte by byte into the filter and predicts each verdict
// (runt, destination address, FCS, ethertype, length) from the accepted bytes.
// Every verdict is checked field by field against the oldest prediction.
// The register settings change between traffic phases, covering the extremes.
// Random gaps on the byte side and random stalls on the verdict side vary the
// timing of every part of the flow.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_filter_top_test;
  import erff_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  rx_beat_t in_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  verdict_t out_o;
  logic out_stall_i = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ethernet_rx_frame_filter_top dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_i(in_i),
    .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o),
    .out_o(out_o),
    .out_stall_i(out_stall_i),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  rx_beat_t rx_bytes_queued[$];
  verdict_t verdicts_due[$];

  logic [47:0] own_mac_q;
  logic addr_chk_q;
  logic fcs_chk_q;

  int unsigned byte_cnt;
  logic [31:0] crc_q;
  logic [31:0] tail_q;
  logic own_hit;
  logic bcast_hit;
  logic [15:0] etype_q;

  logic gaps_on;
  logic stalls_on;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  logic [15:0] known_etypes[5];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  task automatic clear_frame();
    byte_cnt = 0;
    crc_q = CRC_INIT;
    tail_q = '0;
    own_hit = 1'b1;
    bcast_hit = 1'b1;
    etype_q = '0;
  endtask

  task automatic filter_byte(input rx_beat_t beat);
    int unsigned pos;
    int unsigned len;
    logic [2:0] st;
    logic [2:0] pr;
    logic [31:0] fcs;
    verdict_t v;
    pos = byte_cnt;
    if (pos < 6) begin
      if (beat.frame_byte != own_mac_q[8*(5-pos) +: 8]) own_hit = 1'b0;
      if (beat.frame_byte != 8'hFF) bcast_hit = 1'b0;
    end
    if (pos == 12) etype_q[15:8] = beat.frame_byte;
    if (pos == 13) etype_q[7:0] = beat.frame_byte;
    if (pos >= 4) crc_q = crc_step(crc_q, tail_q[31:24]);
    tail_q = {tail_q[23:0], beat.frame_byte};
    if (byte_cnt < MAX_FRAME_BYTES) byte_cnt++;
    if (!beat.frame_end) return;
    len = byte_cnt;
    st = STATUS_OK;
    pr = PROTO_IPV4;
    if (len < 14) begin
      st = STATUS_RUNT;
    end else if (addr_chk_q && !own_hit && !bcast_hit) begin
      st = STATUS_ADDR;
    end else begin
      if (fcs_chk_q && len > 18) begin
        fcs = {tail_q[7:0], tail_q[15:8], tail_q[23:16], tail_q[31:24]};
        len -= 4;
        if (~crc_q != fcs) st = STATUS_BAD_FCS;
      end
      if (st == STATUS_OK) begin
        case (etype_q)
          ETYPE_IPV4: pr = PROTO_IPV4;
          ETYPE_IPV6: pr = PROTO_IPV6;
          ETYPE_ARP: pr = PROTO_ARP;
          ETYPE_PPPOE_DISC: pr = PROTO_PPPOE_DISC;
          ETYPE_PPPOE_SESS: pr = PROTO_PPPOE_SESS;
          default: st = STATUS_ETYPE;
        endcase
      end
    end
    v.accepted = (st == STATUS_OK);
    v.status = st;
    v.protocol = (st == STATUS_OK) ? pr : PROTO_IPV4;
    v.frame_length = len[LEN_W-1:0];
    verdicts_due.push_back(v);
    clear_frame();
  endtask

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    if (err_cnt < 40) begin
      $display("mismatch on %s: expected %0d, got %0d (cycle %0d)", field, want, got,
               cycle_cnt);
    end
    err_cnt++;
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin : drive
      logic nv;
      nv = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        filter_byte(in_i);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_bytes_queued.size() > 0) begin
          in_i <= rx_bytes_queued.pop_front();
          nv = 1'b1;
          gap_left = gaps_on ? $urandom_range(0, 7) : 0;
        end
      end
      in_valid_i <= nv;
    end
  end

  // verdict monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin : watch
      verdict_t want;
      if (out_valid_o && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          report("verdict with nothing due", 0, 1);
        end else begin
          want = verdicts_due.pop_front();
          if (out_o.accepted !== want.accepted)
            report("accepted", 32'(want.accepted), 32'(out_o.accepted));
          if (out_o.status !== want.status)
            report("status", 32'(want.status), 32'(out_o.status));
          if (out_o.protocol !== want.protocol)
            report("protocol", 32'(want.protocol), 32'(out_o.protocol));
          if (out_o.frame_length !== want.frame_length)
            report("frame_length", 32'(want.frame_length), 32'(out_o.frame_length));
        end
        stall_left = stalls_on ? $urandom_range(0, 7) : 0;
      end else if (out_valid_o && stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OWN_MAC: own_mac_q = val[47:0];
      REG_ADDR_CHK: addr_chk_q = val[0];
      REG_FCS_CHK: fcs_chk_q = val[0];
      default: ;
    endcase
  endtask

  // hold until every byte is sent and every verdict is in, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (rx_bytes_queued.size() != 0 || in_valid_i || verdicts_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_frame(input int unsigned len, input logic [47:0] dest,
                             input logic [15:0] etype, input bit good_fcs);
    logic [7:0] fb[];
    logic [31:0] crc;
    rx_beat_t beat;
    fb = new[len];
    for (int i = 0; i < len; i++) begin
      if (i < 6) fb[i] = dest[8*(5-i) +: 8];
      else if (i == 12) fb[i] = etype[15:8];
      else if (i == 13) fb[i] = etype[7:0];
      else fb[i] = 8'($urandom_range(0, 255));
    end
    if (len > 18) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 4; i++) crc = crc_step(crc, fb[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) fb[len-4+i] = crc[8*i +: 8];
      if (!good_fcs) fb[len - 1 - $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < len; i++) begin
      beat.frame_byte = fb[i];
      beat.frame_end = (i == len - 1);
      rx_bytes_queued.push_back(beat);
    end
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int unsigned frames;
    int unsigned bytes_sent;
    int unsigned len;
    logic [47:0] dest;
    logic [15:0] etype;
    bit good;
    known_etypes = '{ETYPE_IPV4, ETYPE_IPV6, ETYPE_ARP, ETYPE_PPPOE_DISC, ETYPE_PPPOE_SESS};
    own_mac_q = '0;
    addr_chk_q = 1'b0;
    fcs_chk_q = 1'b0;
    clear_frame();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    err_cnt = 0;
    cycle_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: runts and every ethertype
    queue_frame(1, MAC_BCAST, ETYPE_IPV4, 1'b1);
    queue_frame(13, rand_mac(), ETYPE_IPV4, 1'b1);
    foreach (known_etypes[i]) queue_frame(14, rand_mac(), known_etypes[i], 1'b1);
    queue_frame(14, '0, 16'hFFFF, 1'b1);
    wait_idle();

    own_mac_q = rand_mac();
    apb_write(REG_OWN_MAC, {16'hFFFF, own_mac_q});
    apb_write(REG_ADDR_CHK, 64'd1);
    apb_write(REG_FCS_CHK, 64'd1);
    apb_write(REG_UNUSED, rand_word());
    queue_frame(18, own_mac_q, ETYPE_ARP, 1'b0);
    queue_frame(19, own_mac_q, ETYPE_IPV6, 1'b1);
    queue_frame(64, MAC_BCAST, ETYPE_IPV4, 1'b0);
    queue_frame(64, own_mac_q ^ 48'h1, ETYPE_IPV4, 1'b1);
    queue_frame(64, MAC_BCAST, 16'h0000, 1'b1);
    queue_frame(64, own_mac_q ^ 48'h8000_0000_0000, ETYPE_PPPOE_SESS, 1'b1);
    queue_frame(13, rand_mac(), ETYPE_IPV4, 1'b1);
    wait_idle();

    apb_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(REG_FCS_CHK, 64'hFFFF_FFFF_FFFF_FFFE);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    queue_frame(20, MAC_BCAST, ETYPE_PPPOE_DISC, 1'b0);
    queue_frame(120, MAC_BCAST, ETYPE_IPV4, 1'b1);
    queue_frame(60, '0, ETYPE_IPV4, 1'b1);
    wait_idle();

    apb_write(REG_OWN_MAC, 64'd0);
    apb_write(REG_ADDR_CHK, 64'd2);
    apb_write(REG_FCS_CHK, 64'hFFFF_FFFF_FFFF_FFFF);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    queue_frame(95, rand_mac(), ETYPE_IPV6, 1'b1);
    queue_frame(19, '0, ETYPE_ARP, 1'b0);
    queue_frame(30, '0, ETYPE_ARP, 1'b1);

    // random traffic, mostly well-formed frames for the current station
    frames = 0;
    bytes_sent = 0;
    while (bytes_sent < 1050) begin
      if (frames % 15 == 0) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: apb_write(REG_OWN_MAC, 64'd0);
          1: apb_write(REG_OWN_MAC, {16'd0, MAC_BCAST});
          default: apb_write(REG_OWN_MAC, rand_word());
        endcase
        apb_write(REG_ADDR_CHK, rand_word());
        apb_write(REG_FCS_CHK, rand_word());
        if ($urandom_range(0, 3) == 0) apb_write(REG_UNUSED, rand_word());
        gaps_on = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      dest = $urandom_range(0, 1) ? own_mac_q : MAC_BCAST;
      etype = known_etypes[$urandom_range(0, 4)];
      len = $urandom_range(19, 72);
      good = 1'b1;
      case ($urandom_range(0, 19))
        0: len = $urandom_range(1, 13);
        1: len = $urandom_range(14, 18);
        2: dest = rand_mac();
        3: dest = own_mac_q ^ (48'd1 << $urandom_range(0, 47));
        4: good = 1'b0;
        5: etype = 16'($urandom_range(0, 65535));
        6: begin
          dest = rand_mac();
          good = 1'b0;
        end
        default: ;
      endcase
      queue_frame(len, dest, etype, good);
      bytes_sent += len;
      frames++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
